// File: design/failsafe_and_arming_supervisor_unit_defines.svh
// assertion macros for the failsafe and arming supervisor
`ifndef FAILSAFE_AND_ARMING_SUPERVISOR_UNIT_DEFINES_SVH
`define FAILSAFE_AND_ARMING_SUPERVISOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked on clk, off during reset
`define FASU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fasu assertion failed");
// next-cycle implication, checked on clk, off during reset
`define FASU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fasu assertion failed");
`else
`define FASU_ASSERT_NOW(lbl, ante, cons)
`define FASU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/fasu_pkg.sv
// shared types and codes for the failsafe and arming supervisor
`default_nettype none
package fasu_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgTW  = 24;
  localparam int unsigned ThrW   = 13;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned MaskW  = 4;
  localparam int unsigned CfgAW  = 3;
  localparam int unsigned CfgDW  = 24;

  // failsafe phases
  localparam logic [PhaseW-1:0] PH_IDLE     = 3'd0;
  localparam logic [PhaseW-1:0] PH_HOLD     = 3'd1;
  localparam logic [PhaseW-1:0] PH_STAGE1   = 3'd2;
  localparam logic [PhaseW-1:0] PH_STAGE2   = 3'd3;
  localparam logic [PhaseW-1:0] PH_RECOVERY = 3'd4;

  // disable mask bits
  localparam logic [MaskW-1:0] DIS_FAILSAFE   = 4'b0001;
  localparam logic [MaskW-1:0] DIS_USB        = 4'b0010;
  localparam logic [MaskW-1:0] DIS_ARM_SWITCH = 4'b0100;
  localparam logic [MaskW-1:0] DIS_THROTTLE   = 4'b1000;

  // register indexes
  localparam logic [CfgAW-1:0] REG_HOLD_TIME     = 3'd0;
  localparam logic [CfgAW-1:0] REG_GUARD_TIME    = 3'd1;
  localparam logic [CfgAW-1:0] REG_RECOVERY_TIME = 3'd2;
  localparam logic [CfgAW-1:0] REG_THR_SAFETY    = 3'd3;
  localparam logic [CfgAW-1:0] REG_PREARM_CYCLE  = 3'd4;

  // register reset values
  localparam logic [CfgTW-1:0] HOLD_TIME_RST     = 24'd250000;
  localparam logic [CfgTW-1:0] GUARD_TIME_RST    = 24'd1000000;
  localparam logic [CfgTW-1:0] RECOVERY_TIME_RST = 24'd1000000;
  localparam logic [ThrW-1:0]  THR_SAFETY_RST    = 13'd410;

  typedef struct packed {
    logic [CfgTW-1:0] hold_time;
    logic [CfgTW-1:0] guard_time;
    logic [CfgTW-1:0] recovery_time;
    logic [ThrW-1:0]  thr_limit;
    logic             prearm_needs_cycle;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_time;
    logic             receiver_ready;
    logic             signal_lost;
    logic [TimeW-1:0] last_frame_time;
    logic             arm_switch;
    logic             prearm_switch;
    logic             usb_link;
    logic [ThrW-1:0]  throttle_level;
    logic             turtle_requested;
    logic             turtle_rdy;
  } item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [TimeW-1:0]  phase_start;
    logic              fs_flag;
    logic              blocked;
    logic              override;
  } fs_state_t;

  // arm bits that the failsafe drop path touches
  typedef struct packed {
    logic armed;
    logic rearm_hold;
  } arm_link_t;

  typedef struct packed {
    logic             checked_arm;
    logic             ready_seen;
    logic [MaskW-1:0] disable_latch;
    logic             was_failsafe;
    logic             prearm_ok;
  } arm_state_t;

  typedef struct packed {
    logic              armed;
    logic [MaskW-1:0]  disable_mask;
    logic              fs_engaged;
    logic              outputs_blocked;
    logic [PhaseW-1:0] phase;
    logic              neutral_override;
    logic              motor_forward_strobe;
  } result_t;

endpackage
`default_nettype wire

// File: design/fasu_fs.sv
// failsafe phase machine, next-state logic for one tick
`default_nettype none
module fasu_fs
  import fasu_pkg::*;
(
  input  var cfg_t      cfg,
  input  var item_t     item,
  input  var fs_state_t cur,
  input  var arm_link_t lnk_cur,
  output fs_state_t     nxt,
  output arm_link_t     lnk_nxt
);

  logic [TimeW-1:0] loss;
  logic [CfgTW:0]   hold_guard;
  logic             lt_hold;
  logic             lt_guard;
  logic [TimeW-1:0] since_start;
  logic             rec_done;
  logic             drop_ovr;
  logic             go_drop;

  assign loss        = item.now_time - item.last_frame_time;
  assign hold_guard  = {1'b0, cfg.hold_time} + {1'b0, cfg.guard_time};
  assign lt_hold     = loss < {{(TimeW-CfgTW){1'b0}}, cfg.hold_time};
  // loss - hold < guard, with loss >= hold already known
  assign lt_guard    = loss < {{(TimeW-CfgTW-1){1'b0}}, hold_guard};
  assign since_start = item.now_time - cur.phase_start;
  assign rec_done    = since_start >= {{(TimeW-CfgTW){1'b0}}, cfg.recovery_time};

  always_comb begin
    nxt      = cur;
    lnk_nxt  = lnk_cur;
    drop_ovr = 1'b0;
    go_drop  = 1'b0;
    if (!item.receiver_ready) begin
      nxt.fs_flag = 1'b1;
      nxt.blocked = 1'b1;
      drop_ovr    = 1'b1;
      nxt.phase   = PH_IDLE;
    end else if (item.signal_lost) begin
      if (cur.phase == PH_STAGE2 || cur.phase == PH_RECOVERY) begin
        go_drop = 1'b1;
      end else if (lt_hold) begin
        nxt.fs_flag = 1'b0;
        nxt.blocked = 1'b0;
        nxt.phase   = PH_HOLD;
      end else if (lt_guard) begin
        nxt.fs_flag  = 1'b1;
        nxt.blocked  = 1'b0;
        nxt.phase    = PH_STAGE1;
        nxt.override = 1'b1;
      end else begin
        drop_ovr = 1'b1;
        go_drop  = 1'b1;
      end
    end else if (cur.phase == PH_STAGE2) begin
      nxt.fs_flag = 1'b1;
      nxt.blocked = 1'b1;
      nxt.phase   = PH_RECOVERY;
    end else if (cur.phase == PH_RECOVERY) begin
      nxt.fs_flag = !rec_done;
      nxt.blocked = !rec_done;
      if (rec_done) begin
        nxt.phase = PH_IDLE;
      end
    end else begin
      nxt.fs_flag = 1'b0;
      nxt.blocked = 1'b0;
      drop_ovr    = 1'b1;
      nxt.phase   = PH_IDLE;
    end

    if (go_drop) begin
      nxt.fs_flag = 1'b1;
      nxt.blocked = 1'b1;
      nxt.phase   = PH_STAGE2;
      if (lnk_cur.armed) begin
        lnk_nxt.rearm_hold = 1'b1;
      end
      lnk_nxt.armed = 1'b0;
    end

    // override only drops when leaving from the stage-1 guard
    if (drop_ovr && cur.phase == PH_STAGE1) begin
      nxt.override = 1'b0;
    end

    nxt.phase_start = (nxt.phase != cur.phase) ? item.now_time : cur.phase_start;
  end

endmodule
`default_nettype wire

// File: design/fasu_arm.sv
// arming logic: disable latch, prearm cycling, rearm hold, throttle check
`default_nettype none
module fasu_arm
  import fasu_pkg::*;
(
  input  var cfg_t       cfg,
  input  var item_t      item,
  input  var fs_state_t  fs_new,
  input  var arm_link_t  lnk,
  input  var arm_state_t cur,
  output arm_link_t      lnk_nxt,
  output arm_state_t     nxt,
  output result_t        res
);

  logic             thr_safe;
  logic             fa;
  logic             fda;
  logic             pre_allows;
  logic             can_arm;
  logic             strobe;
  logic [MaskW-1:0] mask;

  assign thr_safe = item.throttle_level <= cfg.thr_limit;
  assign fa       = fs_new.fs_flag || item.signal_lost;
  assign fda      = fa && (!lnk.armed || fs_new.blocked);

  always_comb begin
    nxt        = cur;
    lnk_nxt    = lnk;
    strobe     = 1'b0;
    pre_allows = 1'b0;
    can_arm    = 1'b0;
    mask       = '0;

    if (!cfg.prearm_needs_cycle || !item.prearm_switch) begin
      nxt.prearm_ok = 1'b1;
    end
    if (!item.prearm_switch) begin
      lnk_nxt.rearm_hold = 1'b0;
    end

    if (cur.was_failsafe && !fa && !item.arm_switch) begin
      nxt.disable_latch = nxt.disable_latch & ~DIS_ARM_SWITCH;
    end
    nxt.was_failsafe = fa;

    if (!item.receiver_ready) begin
      nxt.ready_seen = 1'b0;
    end
    if (fda) begin
      mask = mask | DIS_FAILSAFE;
    end
    if (item.usb_link) begin
      mask = mask | DIS_USB;
    end

    if (item.arm_switch && ((fa && !lnk.armed) || item.usb_link)) begin
      nxt.disable_latch = nxt.disable_latch | DIS_ARM_SWITCH;
    end

    if (item.arm_switch && !item.usb_link && (lnk.armed || !fa)) begin
      pre_allows = item.prearm_switch &&
                   (!cfg.prearm_needs_cycle || nxt.prearm_ok || lnk_nxt.rearm_hold);
      can_arm    = !fa && !cur.checked_arm && (nxt.disable_latch == '0) &&
                   pre_allows && thr_safe;
      if (can_arm) begin
        lnk_nxt.armed = 1'b1;
        if (cfg.prearm_needs_cycle) begin
          nxt.prearm_ok = 1'b0;
        end
        lnk_nxt.rearm_hold = 1'b0;
        strobe = !item.turtle_rdy;
      end else if (!lnk.armed) begin
        nxt.disable_latch = nxt.disable_latch | (thr_safe ? DIS_ARM_SWITCH : DIS_THROTTLE);
      end
      nxt.checked_arm = 1'b1;
    end else begin
      lnk_nxt.armed   = 1'b0;
      nxt.checked_arm = 1'b0;
      if (item.receiver_ready && !item.arm_switch) begin
        if (nxt.ready_seen) begin
          nxt.disable_latch = nxt.disable_latch & ~DIS_ARM_SWITCH;
        end
        nxt.ready_seen = 1'b1;
      end
      nxt.disable_latch = nxt.disable_latch & ~DIS_THROTTLE;
    end

    if (item.turtle_requested && !item.turtle_rdy) begin
      nxt.disable_latch = nxt.disable_latch | DIS_ARM_SWITCH;
    end

    mask = mask | nxt.disable_latch;
    if (mask != '0) begin
      lnk_nxt.armed = 1'b0;
    end

    res.armed                = lnk_nxt.armed;
    res.disable_mask         = mask;
    res.fs_engaged           = fs_new.fs_flag;
    res.outputs_blocked      = fs_new.blocked;
    res.phase                = fs_new.phase;
    res.neutral_override     = fs_new.override;
    res.motor_forward_strobe = strobe;
  end

endmodule
`default_nettype wire

// File: design/failsafe_and_arming_supervisor_unit.sv
// an accepted input beat passes the input register, then the result register, to its result beat
// throughput: one tick per cycle while out_stall is low; the failsafe and arming state updates in a
// single pass per tick, so the state feedback loop sets the rate
// reset: synchronous active-low; failsafe asserted and outputs blocked, phase idle,
// disarmed, arm-switch disable bit latched, registers at their default values
`default_nettype none
`include "failsafe_and_arming_supervisor_unit_defines.svh"
module failsafe_and_arming_supervisor_unit
  import fasu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [CfgAW-1:0]  cfg_addr,
  input  wire logic [CfgDW-1:0]  cfg_wdata,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [TimeW-1:0]  in_now_time,
  input  wire logic              in_receiver_ready,
  input  wire logic              in_signal_lost,
  input  wire logic [TimeW-1:0]  in_last_frame_time,
  input  wire logic              in_arm_switch,
  input  wire logic              in_prearm_switch,
  input  wire logic              in_usb_link,
  input  wire logic [ThrW-1:0]   in_throttle_level,
  input  wire logic              in_turtle_requested,
  input  wire logic              in_turtle_rdy,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_armed,
  output logic [MaskW-1:0]       out_disable_mask,
  output logic                   out_fs_engaged,
  output logic                   out_outputs_blocked,
  output logic [PhaseW-1:0]      out_phase,
  output logic                   out_neutral_override,
  output logic                   out_motor_forward_strobe
);

  // configuration registers
  cfg_t       cfg_r;

  // input stage
  logic       in_valid_r;
  item_t      item_r;
  logic       in_take;

  // supervisor state
  fs_state_t  fs_r;
  fs_state_t  fs_nxt;
  arm_link_t  lnk_r;
  arm_link_t  lnk_fs;
  arm_link_t  lnk_nxt;
  arm_state_t arm_r;
  arm_state_t arm_nxt;

  // result stage
  logic       out_valid_r;
  result_t    res_nxt;
  result_t    res_r;
  logic       proc;

  // a tick is processed when the result register is free or being drained,
  // so a waiting result blocks the next input beat only while out_stall holds it
  assign proc     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  // register writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time          <= HOLD_TIME_RST;
      cfg_r.guard_time         <= GUARD_TIME_RST;
      cfg_r.recovery_time      <= RECOVERY_TIME_RST;
      cfg_r.thr_limit          <= THR_SAFETY_RST;
      cfg_r.prearm_needs_cycle <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HOLD_TIME:     cfg_r.hold_time          <= cfg_wdata[CfgTW-1:0];
        REG_GUARD_TIME:    cfg_r.guard_time         <= cfg_wdata[CfgTW-1:0];
        REG_RECOVERY_TIME: cfg_r.recovery_time      <= cfg_wdata[CfgTW-1:0];
        REG_THR_SAFETY:    cfg_r.thr_limit          <= cfg_wdata[ThrW-1:0];
        REG_PREARM_CYCLE:  cfg_r.prearm_needs_cycle <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_take || (in_valid_r && !proc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.now_time         <= in_now_time;
      item_r.receiver_ready   <= in_receiver_ready;
      item_r.signal_lost      <= in_signal_lost;
      item_r.last_frame_time  <= in_last_frame_time;
      item_r.arm_switch       <= in_arm_switch;
      item_r.prearm_switch    <= in_prearm_switch;
      item_r.usb_link         <= in_usb_link;
      item_r.throttle_level   <= in_throttle_level;
      item_r.turtle_requested <= in_turtle_requested;
      item_r.turtle_rdy       <= in_turtle_rdy;
    end
  end

  // failsafe phases run first; their drop path can disarm and set rearm hold
  fasu_fs u_fs (
    .cfg     (cfg_r),
    .item    (item_r),
    .cur     (fs_r),
    .lnk_cur (lnk_r),
    .nxt     (fs_nxt),
    .lnk_nxt (lnk_fs)
  );

  // arming works on the post-failsafe flags of the same tick
  fasu_arm u_arm (
    .cfg     (cfg_r),
    .item    (item_r),
    .fs_new  (fs_nxt),
    .lnk     (lnk_fs),
    .cur     (arm_r),
    .lnk_nxt (lnk_nxt),
    .nxt     (arm_nxt),
    .res     (res_nxt)
  );

  // state update, one tick per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r.phase          <= PH_IDLE;
      fs_r.phase_start    <= '0;
      fs_r.fs_flag        <= 1'b1;
      fs_r.blocked        <= 1'b1;
      fs_r.override       <= 1'b0;
      lnk_r.armed         <= 1'b0;
      lnk_r.rearm_hold    <= 1'b0;
      arm_r.checked_arm   <= 1'b0;
      arm_r.ready_seen    <= 1'b0;
      arm_r.disable_latch <= DIS_ARM_SWITCH;
      arm_r.was_failsafe  <= 1'b0;
      arm_r.prearm_ok     <= 1'b1;
    end else if (proc) begin
      fs_r  <= fs_nxt;
      lnk_r <= lnk_nxt;
      arm_r <= arm_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= proc || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_armed                = res_r.armed;
  assign out_disable_mask         = res_r.disable_mask;
  assign out_fs_engaged           = res_r.fs_engaged;
  assign out_outputs_blocked      = res_r.outputs_blocked;
  assign out_phase                = res_r.phase;
  assign out_neutral_override     = res_r.neutral_override;
  assign out_motor_forward_strobe = res_r.motor_forward_strobe;

  // blocked outputs only ever come with the failsafe flag
  `FASU_ASSERT_NOW(a_blocked_implies_fs, fs_r.blocked, fs_r.fs_flag)
  // an armed result never carries a disable reason
  `FASU_ASSERT_NOW(a_armed_clean, out_valid_r && out_armed, out_disable_mask == '0)
  // the forward strobe only fires with failsafe clear
  `FASU_ASSERT_NOW(a_strobe_no_fs, out_valid_r && out_motor_forward_strobe, !out_fs_engaged)
  // a processed tick always lands in the result register
  `FASU_ASSERT_NEXT(a_proc_lands, proc, out_valid_r)
  // phase start only moves on a phase change
  `FASU_ASSERT_NEXT(a_start_steady, proc && (fs_nxt.phase == fs_r.phase), $stable(fs_r.phase_start))

endmodule
`default_nettype wire
